/* rtl/fmm_pkg.sv */
// Shared types and constants for the formula molar mass parser.
`timescale 1ns / 1ps
package fmm_pkg;
    localparam int NUM_BITS = 16;
    localparam logic [NUM_BITS-1:0] NUM_MAX = 16'hFFFF;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CHAR = 1'b1;

    localparam logic [6:0] CH_0  = 7'h30;
    localparam logic [6:0] CH_9  = 7'h39;
    localparam logic [6:0] CH_LA = 7'h61;
    localparam logic [6:0] CH_LZ = 7'h7A;
    localparam logic [6:0] CH_OP = 7'h28;
    localparam logic [6:0] CH_CP = 7'h29;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OPEN  = 2'd1;
    localparam logic [1:0] ST_LONG  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // write table entry
        OP_COEF_DIG,  // leading_coeff = leading_coeff*10+d
        OP_CNT_DIG,   // count = count*10+d
        OP_CNT_CLR,
        OP_GRP_OPEN,
        OP_SYM_START,
        OP_SYM_CHAR,
        OP_SRCH_START,// begin table search for symbol
        OP_SRCH_STEP, // examine one table entry
        OP_SYM_ADD,   // weight*count, add
        OP_GRP_CLOSE, // group_sum*mult into total
        OP_GRP_FORCE, // unclosed group: flag, close with 1
        OP_FINAL,     // total*coeff
        OP_DIV_STEP,  // one step of the shift-add divide by ten
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic srch_done;
        logic div_done;
        logic in_group;
    } dp_status_t;
endpackage

/* rtl/fmm_datapath.sv */
// Datapath: symbol table, accumulators, multiply/add with saturation, divide by ten.
`timescale 1ns / 1ps
module fmm_datapath #(
    parameter int TABLE_ENTRIES = 128,
    parameter int SYMBOL_CHARS  = 3,
    parameter int TOTAL_BITS    = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fmm_pkg::op_t         op,
    input  logic [6:0]           ch,
    input  logic [6:0]           ld_index,
    input  logic [23:0]          ld_symbol,
    input  logic [15:0]          ld_mass,
    output fmm_pkg::dp_status_t  status,
    output logic [TOTAL_BITS-1:0] total_q,
    output logic [TOTAL_BITS-1:0] quot_q,
    output logic [3:0]           rem_q,
    output logic [1:0]           flags_q
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int KW = 8 * SYMBOL_CHARS;
    localparam int LW = $clog2(SYMBOL_CHARS + 2);
    localparam int CW = $clog2(TOTAL_BITS + 1);
    localparam int SW = (KW < 24) ? KW : 24;
    localparam int DIV_STEPS = 8;
    localparam logic [TOTAL_BITS-1:0] TOT_MAX = '1;

    logic [KW-1:0]  key_mem [TABLE_ENTRIES];
    logic [15:0]    mass_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    logic [15:0] coeff_reg, count_reg;
    logic [KW-1:0] sym_reg;
    logic [LW-1:0] len_reg;
    logic grp_reg;
    logic [TOTAL_BITS-1:0] gsum_reg, total_reg, quot_reg;
    logic [1:0] flags_reg;
    logic [IW:0] sidx_reg;
    logic srch_done_reg;
    logic [15:0] weight_reg;
    logic [KW-1:0] rd_key_reg;
    logic [15:0] rd_mass_reg;
    logic rd_valid_reg, rd_pend_reg;
    logic [4:0] rem_reg;
    logic [CW-1:0] dcnt_reg;

    // digit accumulation
    logic [3:0] dig;
    logic [15:0] num_src;
    logic [20:0] num_acc;
    always_comb begin
        dig = ch[3:0] - fmm_pkg::CH_0[3:0];
        num_src = (op == fmm_pkg::OP_COEF_DIG) ? coeff_reg : count_reg;
        num_acc = {5'd0, num_src} * 21'd10 + {17'd0, dig};
    end

    // shared saturating multiply-add
    logic [TOTAL_BITS-1:0] mul_a, mul_b, add_b;
    logic [2*TOTAL_BITS-1:0] prod;
    logic [TOTAL_BITS:0] sum;
    logic prod_sat, sum_sat;
    logic [TOTAL_BITS-1:0] prod_v, sum_v;
    logic [15:0] cnt1, mul1;
    always_comb begin
        cnt1 = (count_reg == '0) ? 16'd1 : count_reg;
        mul1 = (coeff_reg == '0) ? 16'd1 : coeff_reg;
        mul_a = '0; mul_b = '0; add_b = '0;
        unique case (op)
            fmm_pkg::OP_SYM_ADD: begin
                mul_a = TOTAL_BITS'(weight_reg); mul_b = TOTAL_BITS'(cnt1);
                add_b = grp_reg ? gsum_reg : total_reg;
            end
            fmm_pkg::OP_GRP_CLOSE: begin
                mul_a = gsum_reg; mul_b = TOTAL_BITS'(cnt1); add_b = total_reg;
            end
            fmm_pkg::OP_GRP_FORCE: begin
                mul_a = gsum_reg; mul_b = TOTAL_BITS'(1); add_b = total_reg;
            end
            fmm_pkg::OP_FINAL: begin
                mul_a = total_reg; mul_b = TOTAL_BITS'(mul1); add_b = '0;
            end
            default: ;
        endcase
        prod = mul_a * {{TOTAL_BITS-16{1'b0}}, mul_b[15:0]};
        prod_sat = |prod[2*TOTAL_BITS-1:TOTAL_BITS];
        prod_v = prod_sat ? TOT_MAX : prod[TOTAL_BITS-1:0];
        sum = {1'b0, prod_v} + {1'b0, add_b};
        sum_sat = sum[TOTAL_BITS];
        sum_v = sum_sat ? TOT_MAX : sum[TOTAL_BITS-1:0];
    end

    // remainder left by the reciprocal estimate of the quotient, below twenty
    logic [TOTAL_BITS-1:0] rem_full;
    assign rem_full = total_reg - (quot_reg << 3) - (quot_reg << 1);

    function automatic logic [1:0] fmax(input logic [1:0] a, input logic [1:0] b);
        fmax = (b > a) ? b : a;
    endfunction

    // table memory
    always_ff @(posedge aclk) begin
        if (op == fmm_pkg::OP_LOAD && {1'b0, ld_index} < (IW+1 > 8 ? (IW+1)'(TABLE_ENTRIES)
            : 8'(TABLE_ENTRIES))) begin
            key_mem[ld_index[IW-1:0]]  <= KW'(ld_symbol[23 -: SW]) << (KW - SW);
            mass_mem[ld_index[IW-1:0]] <= ld_mass;
        end
        rd_key_reg  <= key_mem[sidx_reg[IW-1:0]];
        rd_mass_reg <= mass_mem[sidx_reg[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0; coeff_reg <= '0; count_reg <= '0; sym_reg <= '0;
            len_reg <= '0; grp_reg <= 1'b0; gsum_reg <= '0; total_reg <= '0;
            flags_reg <= fmm_pkg::ST_OK; sidx_reg <= '0; srch_done_reg <= 1'b0;
            weight_reg <= '0; rd_valid_reg <= 1'b0; rd_pend_reg <= 1'b0;
            quot_reg <= '0; rem_reg <= '0; dcnt_reg <= '0;
        end else begin
            unique case (op)
                fmm_pkg::OP_LOAD:
                    if (32'(ld_index) < TABLE_ENTRIES) valid_reg[ld_index[IW-1:0]] <= 1'b1;
                fmm_pkg::OP_COEF_DIG, fmm_pkg::OP_CNT_DIG: begin
                    if (op == fmm_pkg::OP_COEF_DIG)
                        coeff_reg <= (num_acc > 21'(fmm_pkg::NUM_MAX)) ? fmm_pkg::NUM_MAX
                                     : num_acc[15:0];
                    else
                        count_reg <= (num_acc > 21'(fmm_pkg::NUM_MAX)) ? fmm_pkg::NUM_MAX
                                     : num_acc[15:0];
                    if (num_acc > 21'(fmm_pkg::NUM_MAX)) flags_reg <= fmm_pkg::ST_SAT;
                end
                fmm_pkg::OP_CNT_CLR: count_reg <= '0;
                fmm_pkg::OP_GRP_OPEN: begin
                    grp_reg <= 1'b1; gsum_reg <= '0;
                end
                fmm_pkg::OP_SYM_START: begin
                    // a symbol that ends without a count counts once
                    sym_reg <= KW'({ch, 1'b0}) >> 1 << (KW - 8);
                    len_reg <= LW'(1);
                    count_reg <= '0;
                end
                fmm_pkg::OP_SYM_CHAR: begin
                    if (32'(len_reg) < SYMBOL_CHARS)
                        sym_reg <= sym_reg | (KW'({1'b0, ch}) << (8 * (SYMBOL_CHARS - 1
                                   - 32'(len_reg))));
                    if (32'(len_reg) <= SYMBOL_CHARS) len_reg <= len_reg + LW'(1);
                end
                fmm_pkg::OP_SRCH_START: begin
                    weight_reg <= '0; sidx_reg <= '0; rd_pend_reg <= 1'b0;
                    rd_valid_reg <= 1'b0;
                    if (32'(len_reg) > SYMBOL_CHARS) begin
                        flags_reg <= fmax(flags_reg, fmm_pkg::ST_LONG);
                        srch_done_reg <= 1'b1;
                    end else begin
                        srch_done_reg <= 1'b0;
                    end
                end
                fmm_pkg::OP_SRCH_STEP: begin
                    // address issued one cycle, data compared the next
                    rd_valid_reg <= valid_reg[sidx_reg[IW-1:0]];
                    rd_pend_reg <= (32'(sidx_reg) < TABLE_ENTRIES);
                    if (!srch_done_reg) begin
                        if (rd_pend_reg && rd_valid_reg && rd_key_reg == sym_reg) begin
                            weight_reg <= rd_mass_reg; srch_done_reg <= 1'b1;
                        end else if (sidx_reg[IW] || 32'(sidx_reg) >= TABLE_ENTRIES) begin
                            if (!rd_pend_reg) srch_done_reg <= 1'b1;
                        end else begin
                            sidx_reg <= sidx_reg + (IW+1)'(1);
                        end
                        if (32'(sidx_reg) >= TABLE_ENTRIES) sidx_reg <= (IW+1)'(TABLE_ENTRIES);
                    end
                end
                fmm_pkg::OP_SYM_ADD: begin
                    if (grp_reg) gsum_reg <= sum_v; else total_reg <= sum_v;
                    if (prod_sat || sum_sat) flags_reg <= fmm_pkg::ST_SAT;
                end
                fmm_pkg::OP_GRP_CLOSE, fmm_pkg::OP_GRP_FORCE: begin
                    total_reg <= sum_v; gsum_reg <= '0; grp_reg <= 1'b0;
                    if (prod_sat || sum_sat) flags_reg <= fmm_pkg::ST_SAT;
                    else if (op == fmm_pkg::OP_GRP_FORCE)
                        flags_reg <= fmax(flags_reg, fmm_pkg::ST_OPEN);
                end
                fmm_pkg::OP_FINAL: begin
                    total_reg <= sum_v; quot_reg <= sum_v; rem_reg <= '0;
                    dcnt_reg <= CW'(DIV_STEPS);
                    if (prod_sat) flags_reg <= fmm_pkg::ST_SAT;
                end
                fmm_pkg::OP_DIV_STEP: begin
                    // quotient by shift-add reciprocal of ten, then one correction
                    unique case (dcnt_reg)
                        CW'(8): quot_reg <= (total_reg >> 1) + (total_reg >> 2);
                        CW'(7): quot_reg <= quot_reg + (quot_reg >> 4);
                        CW'(6): quot_reg <= quot_reg + (quot_reg >> 8);
                        CW'(5): quot_reg <= quot_reg + (quot_reg >> 16);
                        CW'(4): quot_reg <= quot_reg + (quot_reg >> 32);
                        CW'(3): quot_reg <= quot_reg >> 3;
                        CW'(2): rem_reg <= rem_full[4:0];
                        CW'(1):
                            if (rem_reg > 5'd9) begin
                                quot_reg <= quot_reg + TOTAL_BITS'(1);
                                rem_reg <= rem_reg - 5'd10;
                            end
                        default: ;
                    endcase
                    if (dcnt_reg != '0) dcnt_reg <= dcnt_reg - CW'(1);
                end
                fmm_pkg::OP_CLEAR: begin
                    coeff_reg <= '0; count_reg <= '0; sym_reg <= '0; len_reg <= '0;
                    grp_reg <= 1'b0; gsum_reg <= '0; total_reg <= '0;
                    flags_reg <= fmm_pkg::ST_OK;
                end
                default: ;
            endcase
        end
    end

    assign status.srch_done = srch_done_reg;
    assign status.div_done  = (dcnt_reg == '0);
    assign status.in_group  = grp_reg;
    assign total_q = total_reg;
    assign quot_q  = quot_reg;
    assign rem_q   = rem_reg[3:0];
    assign flags_q = flags_reg;
endmodule

/* rtl/fmm_ctrl.sv */
// Controller: parse phases, search/multiply sequencing and result handshake.
`timescale 1ns / 1ps
module fmm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_cmd,
    input  logic [6:0]          in_ch,
    input  logic                in_last,
    output logic [6:0]          ch,
    output fmm_pkg::op_t        op,
    input  fmm_pkg::dp_status_t status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_load
);
    typedef enum logic [2:0] {PH_COEFF, PH_START, PH_SYM, PH_COUNT, PH_MULT} phase_t;
    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SRCH, S_ADD, S_END_SYM, S_END_SRCH, S_END_ADD,
        S_END_GRP, S_END_FORCE, S_FINAL, S_DIV, S_CLEAR
    } state_t;

    state_t state_reg;
    phase_t phase_reg;
    logic [6:0] ch_reg;
    logic last_reg, out_valid_reg;

    logic is_dig, is_low, out_take;
    state_t end_state;
    assign is_dig = (ch_reg >= fmm_pkg::CH_0) && (ch_reg <= fmm_pkg::CH_9);
    assign is_low = (ch_reg >= fmm_pkg::CH_LA) && (ch_reg <= fmm_pkg::CH_LZ);
    assign end_state = last_reg ? S_END_SYM : S_IDLE;
    // result register free, or emptied at this edge
    assign out_take = status.div_done && (!out_valid_reg || out_ready);
    assign ch = ch_reg;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb begin
        op = fmm_pkg::OP_NONE;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
                if (in_valid && in_ready && in_cmd == fmm_pkg::CMD_LOAD) op = fmm_pkg::OP_LOAD;
            S_DISPATCH:
                unique case (phase_reg)
                    PH_COEFF: if (is_dig) op = fmm_pkg::OP_COEF_DIG;
                    PH_START:
                        if (ch_reg == fmm_pkg::CH_OP && !status.in_group)
                            op = fmm_pkg::OP_GRP_OPEN;
                        else if (ch_reg == fmm_pkg::CH_CP && status.in_group)
                            op = fmm_pkg::OP_CNT_CLR;
                        else op = fmm_pkg::OP_SYM_START;
                    PH_SYM:
                        if (is_low) op = fmm_pkg::OP_SYM_CHAR;
                        else op = fmm_pkg::OP_CNT_CLR;
                    PH_COUNT:
                        op = is_dig ? fmm_pkg::OP_CNT_DIG : fmm_pkg::OP_SRCH_START;
                    PH_MULT:
                        op = is_dig ? fmm_pkg::OP_CNT_DIG : fmm_pkg::OP_GRP_CLOSE;
                    default: ;
                endcase
            S_SRCH, S_END_SRCH: op = fmm_pkg::OP_SRCH_STEP;
            S_ADD, S_END_ADD:   op = fmm_pkg::OP_SYM_ADD;
            S_END_SYM:          op = fmm_pkg::OP_SRCH_START;
            S_END_GRP:          op = fmm_pkg::OP_GRP_CLOSE;
            S_END_FORCE:        op = status.in_group ? fmm_pkg::OP_GRP_FORCE : fmm_pkg::OP_NONE;
            S_FINAL:            op = fmm_pkg::OP_FINAL;
            S_DIV: begin
                op = fmm_pkg::OP_DIV_STEP;
                out_load = out_take;
            end
            S_CLEAR:            op = fmm_pkg::OP_CLEAR;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE; phase_reg <= PH_COEFF; ch_reg <= '0;
            last_reg <= 1'b0; out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= (state_reg == S_DIV && out_take) ? 1'b1
                             : (out_ready ? 1'b0 : out_valid_reg);
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready && in_cmd == fmm_pkg::CMD_CHAR) begin
                        ch_reg <= in_ch; last_reg <= in_last; state_reg <= S_DISPATCH;
                    end
                S_DISPATCH:
                    unique case (phase_reg)
                        PH_COEFF:
                            if (!is_dig) begin
                                phase_reg <= PH_START; state_reg <= S_DISPATCH;
                            end else begin
                                state_reg <= end_state;
                            end
                        PH_START: begin
                            if (ch_reg == fmm_pkg::CH_CP && status.in_group)
                                phase_reg <= PH_MULT;
                            else if (!(ch_reg == fmm_pkg::CH_OP && !status.in_group))
                                phase_reg <= PH_SYM;
                            state_reg <= end_state;
                        end
                        PH_SYM:
                            if (!is_low) begin
                                phase_reg <= PH_COUNT; state_reg <= S_DISPATCH;
                            end else begin
                                state_reg <= end_state;
                            end
                        PH_COUNT:
                            state_reg <= is_dig ? end_state : S_SRCH;
                        PH_MULT:
                            if (!is_dig) begin
                                phase_reg <= PH_START; state_reg <= S_DISPATCH;
                            end else begin
                                state_reg <= end_state;
                            end
                        default: state_reg <= S_IDLE;
                    endcase
                S_SRCH: if (status.srch_done) state_reg <= S_ADD;
                S_ADD: begin
                    phase_reg <= PH_START; state_reg <= S_DISPATCH;
                end
                S_END_SYM:
                    // close whatever is open at the last character
                    unique case (phase_reg)
                        PH_SYM, PH_COUNT: state_reg <= S_END_SRCH;
                        PH_MULT:          state_reg <= S_END_GRP;
                        default:          state_reg <= S_END_FORCE;
                    endcase
                S_END_SRCH: if (status.srch_done) state_reg <= S_END_ADD;
                S_END_ADD, S_END_GRP: state_reg <= S_END_FORCE;
                S_END_FORCE: state_reg <= S_FINAL;
                S_FINAL: state_reg <= S_DIV;
                // hold the finished result until the output register is free
                S_DIV: if (out_take) state_reg <= S_CLEAR;
                S_CLEAR: begin
                    phase_reg <= PH_COEFF; state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* rtl/formula_molar_mass_parser_top.sv */
// Top level of the formula molar mass parser: stream ports, controller and datapath.
`timescale 1ns / 1ps
// Channel | Direction | tdata (low bit up)                                | tuser | tlast
// s_      | in        | entry_index, entry_symbol, entry_mass, char_code  | cmd   | last
// m_      | out       | mass_tenths, whole_units, tenth_digit, status      | -     | -
// A load transaction writes its table entry straight from the idle state; a character that
// ends a symbol also starts a scan of the symbol table for that symbol.
// The last character adds the scan for an open symbol, the final multiply and the divide by ten.
// Reset (aresetn low, synchronous) clears the valid bits and the parse state.
// A result waits in the output register; a second one holds the block, and s_tready, until
// the first transaction on m_ is taken.
module formula_molar_mass_parser_top #(
    parameter int TABLE_ENTRIES = 128,
    parameter int SYMBOL_CHARS  = 3,
    parameter int TOTAL_BITS    = 40
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // entry_index[6:0], entry_symbol[30:7], entry_mass[46:31], char_code[53:47]
    input  logic         s_tuser,   // cmd
    input  logic         s_tlast,   // last
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata    // mass_tenths[39:0], whole_units[76:40], tenth_digit[80:77], status[82:81]
);
    fmm_pkg::op_t op;
    fmm_pkg::dp_status_t st;
    logic [6:0] ch;
    logic out_load;
    logic [TOTAL_BITS-1:0] total_q, quot_q;
    logic [3:0] rem_q;
    logic [1:0] flags_q;
    logic [87:0] result_reg;

    fmm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tuser), .in_ch(s_tdata[53:47]), .in_last(s_tlast), .ch(ch), .op(op),
        .status(st), .out_valid(m_tvalid), .out_ready(m_tready), .out_load(out_load)
    );

    fmm_datapath #(
        .TABLE_ENTRIES(TABLE_ENTRIES), .SYMBOL_CHARS(SYMBOL_CHARS), .TOTAL_BITS(TOTAL_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .op(op), .ch(ch), .ld_index(s_tdata[6:0]),
        .ld_symbol(s_tdata[30:7]), .ld_mass(s_tdata[46:31]), .status(st),
        .total_q(total_q), .quot_q(quot_q), .rem_q(rem_q), .flags_q(flags_q)
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            result_reg <= {5'd0, flags_q, rem_q, 37'(quot_q), 40'(total_q)};
        end
    end
    assign m_tdata = result_reg;
endmodule
